>>> src/vrrb_pkg.sv
// Shared constants, types and codes of the variable-length record ring buffer.
// No dependencies; the other design files refer to this package by scoped names, the testbench files import it.
`timescale 1ns / 1ps

package vrrb_pkg;

    localparam int STORE_BYTES = 4096;
    localparam int MAX_RECORD  = 63;

    localparam int PTR_W  = $clog2(STORE_BYTES);
    localparam int HELD_W = $clog2(STORE_BYTES + 1);
    localparam int LEN_W  = 6;
    localparam int CNT_W  = 7;
    localparam int BYTE_W = 8;
    localparam int WORD_W = BYTE_W + 1;
    localparam int KIND_W = 2;
    localparam int FILL_W = 13;

    typedef logic [PTR_W-1:0]  t_ptr;
    typedef logic [WORD_W-1:0] t_word;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_READ  = 1'b1;

    localparam logic [KIND_W-1:0] KIND_WRITE_ACK = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ_DATA = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EMPTY     = 2'd2;

    localparam logic STATUS_STORED  = 1'b0;
    localparam logic STATUS_DROPPED = 1'b1;

    localparam t_word WORD_TERM = {1'b0, {BYTE_W{1'b0}}};
    localparam t_word WORD_WRAP = {1'b1, {BYTE_W{1'b0}}};

    typedef struct packed {
        logic accept;
        logic wrap;
    } t_place;

    typedef struct packed {
        logic  en;
        t_ptr  addr;
        t_word data;
    } t_mem_wr;

endpackage

>>> src/vrrb_if.sv
// Valid/ready channel interfaces for the record ring buffer input and result streams.
// Depends on vrrb_pkg for field widths.
`timescale 1ns / 1ps

interface vrrb_in_if;
    logic                       valid;
    logic                       ready;
    logic                       mode;
    logic [vrrb_pkg::BYTE_W-1:0] byte_value;
    logic [vrrb_pkg::LEN_W-1:0]  record_length;
    logic                       last_byte;

    modport source (output valid, mode, byte_value, record_length, last_byte, input ready);
    modport sink   (input valid, mode, byte_value, record_length, last_byte, output ready);
endinterface

interface vrrb_out_if;
    logic                       valid;
    logic                       ready;
    logic [vrrb_pkg::KIND_W-1:0] kind;
    logic [vrrb_pkg::BYTE_W-1:0] data_byte;
    logic                       end_of_record;
    logic                       write_status;
    logic [vrrb_pkg::CNT_W-1:0]  stored_length;
    logic [vrrb_pkg::FILL_W-1:0] fill_count;

    modport source (output valid, kind, data_byte, end_of_record, write_status, stored_length,
                    fill_count, input ready);
    modport sink   (input valid, kind, data_byte, end_of_record, write_status, stored_length,
                    fill_count, output ready);
endinterface

>>> src/vrrb_store.sv
// Byte store: one write port, one read port with registered read data.
// Depends on vrrb_pkg for the depth, word width and write-port struct.
`timescale 1ns / 1ps

module vrrb_store (
    input  logic              i_clk,
    input  vrrb_pkg::t_mem_wr i_wr,
    input  logic              i_rd_en,
    input  vrrb_pkg::t_ptr    i_rd_addr,
    output vrrb_pkg::t_word   o_rd_data
);

    vrrb_pkg::t_word r_mem [vrrb_pkg::STORE_BYTES];
    vrrb_pkg::t_word r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> src/vrrb_addr_alu.sv
// Shared address adder: base plus offset, wrapped at the end of the store.
// Depends on vrrb_pkg for pointer and count widths.
`timescale 1ns / 1ps

module vrrb_addr_alu (
    input  vrrb_pkg::t_ptr                i_base,
    input  logic [vrrb_pkg::CNT_W-1:0]    i_offset,
    output vrrb_pkg::t_ptr                o_sum
);

    localparam logic [vrrb_pkg::PTR_W:0] SIZE_EXT = (vrrb_pkg::PTR_W + 1)'(vrrb_pkg::STORE_BYTES);

    logic [vrrb_pkg::PTR_W:0] sum_ext;
    logic [vrrb_pkg::PTR_W:0] sum_wrap;

    always_comb begin
        sum_ext  = {1'b0, i_base} + (vrrb_pkg::PTR_W + 1)'(i_offset);
        sum_wrap = (sum_ext >= SIZE_EXT) ? (sum_ext - SIZE_EXT) : sum_ext;
    end

    assign o_sum = sum_wrap[vrrb_pkg::PTR_W-1:0];

endmodule

>>> src/vrrb_place.sv
// Record placement: decides from the pointers whether a new record goes at the tail,
// wraps to the start of the store, or is dropped. Depends on vrrb_pkg.
`timescale 1ns / 1ps

module vrrb_place (
    input  vrrb_pkg::t_ptr             i_wp,
    input  vrrb_pkg::t_ptr             i_rp,
    input  logic                       i_held_zero,
    input  logic [vrrb_pkg::LEN_W-1:0] i_len,
    output vrrb_pkg::t_place           o_place
);

    localparam logic [vrrb_pkg::PTR_W:0] SIZE_EXT = (vrrb_pkg::PTR_W + 1)'(vrrb_pkg::STORE_BYTES);

    logic [vrrb_pkg::PTR_W:0] need;
    logic [vrrb_pkg::PTR_W:0] room_end;
    logic [vrrb_pkg::PTR_W:0] wp_ext;
    logic [vrrb_pkg::PTR_W:0] rp_ext;

    always_comb begin
        wp_ext   = {1'b0, i_wp};
        rp_ext   = {1'b0, i_rp};
        need     = (vrrb_pkg::PTR_W + 1)'(i_len) + (vrrb_pkg::PTR_W + 1)'(1);
        room_end = SIZE_EXT - wp_ext;
        o_place  = '0;
        if (wp_ext > rp_ext) begin
            if (room_end >= need) begin
                o_place.accept = 1'b1;
            end else if (rp_ext >= need) begin
                o_place.accept = 1'b1;
                o_place.wrap   = 1'b1;
            end
        end else if (wp_ext == rp_ext) begin
            if (i_held_zero) begin
                o_place.accept = 1'b1;
                o_place.wrap   = (room_end < need);
            end
        end else begin
            o_place.accept = ((rp_ext - wp_ext) >= need);
        end
    end

endmodule

>>> src/variable_record_ring_buffer.sv
// Variable-length record ring buffer. Write items stream a record in one byte per
// transaction; the record is committed with a terminator on its last byte, or dropped when it
// does not fit, and one write acknowledge is returned. A read item returns the oldest record
// one byte per result, or an empty indication. The block handles one item at a time and holds
// ready low while it works. A stored record is scanned and read through the single read port
// with its registered data and the one shared address adder; a result that waits on the
// output channel holds the block. No clearing pass runs after reset.
// Depends on vrrb_pkg, vrrb_if, vrrb_store, vrrb_addr_alu and vrrb_place.
`timescale 1ns / 1ps

module variable_record_ring_buffer (
    input  logic            i_clk,
    input  logic            i_rst_n,
    vrrb_in_if.sink         i_in,
    vrrb_out_if.source      o_out
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_W_PLACE,
        ST_W_BYTE,
        ST_W_TERM,
        ST_W_MARK,
        ST_W_COMMIT,
        ST_W_ACK,
        ST_R_CHECK,
        ST_R_MARK,
        ST_R_SADDR,
        ST_R_SDATA,
        ST_R_EMPTYREC,
        ST_R_EADDR,
        ST_R_EDATA
    } t_state;

    localparam int HELD_W = vrrb_pkg::HELD_W;
    localparam int LEN_W  = vrrb_pkg::LEN_W;
    localparam int CNT_W  = vrrb_pkg::CNT_W;
    localparam int BYTE_W = vrrb_pkg::BYTE_W;
    localparam int KIND_W = vrrb_pkg::KIND_W;
    localparam int FILL_W = vrrb_pkg::FILL_W;

    t_state r_state, n_state;

    logic              r_mode, n_mode;
    logic [BYTE_W-1:0] r_byte, n_byte;
    logic [LEN_W-1:0]  r_len_in, n_len_in;
    logic              r_last, n_last;

    vrrb_pkg::t_ptr    r_rp, n_rp;
    vrrb_pkg::t_ptr    r_wp, n_wp;
    logic [HELD_W-1:0] r_held, n_held;
    vrrb_pkg::t_ptr    r_cursor, n_cursor;
    logic              r_open, n_open;
    logic              r_accepted, n_accepted;
    logic              r_wrap, n_wrap;
    logic [LEN_W-1:0]  r_rec_len, n_rec_len;
    logic [LEN_W-1:0]  r_used, n_used;

    vrrb_pkg::t_ptr    r_scan_base, n_scan_base;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [CNT_W-1:0]  r_k, n_k;

    logic              r_out_valid, n_out_valid;
    logic [KIND_W-1:0] r_kind, n_kind;
    logic [BYTE_W-1:0] r_data, n_data;
    logic              r_eor, n_eor;
    logic              r_status, n_status;
    logic [CNT_W-1:0]  r_slen, n_slen;
    logic [FILL_W-1:0] r_fill, n_fill;

    vrrb_pkg::t_mem_wr mem_wr;
    logic              rd_en;
    vrrb_pkg::t_ptr    rd_addr;
    vrrb_pkg::t_word   rd_data;

    vrrb_pkg::t_ptr    alu_a;
    logic [CNT_W-1:0]  alu_b;
    vrrb_pkg::t_ptr    alu_sum;

    vrrb_pkg::t_place  place;
    logic [LEN_W-1:0]  len_clamp;

    logic              out_free;
    logic              scan_zero;
    logic [CNT_W-1:0]  cnt_new;
    logic [HELD_W-1:0] consumed;

    vrrb_store u_store (
        .i_clk     (i_clk),
        .i_wr      (mem_wr),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    vrrb_addr_alu u_alu (
        .i_base   (alu_a),
        .i_offset (alu_b),
        .o_sum    (alu_sum)
    );

    vrrb_place u_place (
        .i_wp        (r_wp),
        .i_rp        (r_rp),
        .i_held_zero (r_held == '0),
        .i_len       (len_clamp),
        .o_place     (place)
    );

    assign i_in.ready          = (r_state == ST_IDLE);
    assign o_out.valid         = r_out_valid;
    assign o_out.kind          = r_kind;
    assign o_out.data_byte     = r_data;
    assign o_out.end_of_record = r_eor;
    assign o_out.write_status  = r_status;
    assign o_out.stored_length = r_slen;
    assign o_out.fill_count    = r_fill;

    always_comb begin
        if (r_len_in == '0) begin
            len_clamp = LEN_W'(1);
        end else if (r_len_in > LEN_W'(vrrb_pkg::MAX_RECORD)) begin
            len_clamp = LEN_W'(vrrb_pkg::MAX_RECORD);
        end else begin
            len_clamp = r_len_in;
        end

        out_free  = !r_out_valid || o_out.ready;
        scan_zero = (rd_data[BYTE_W-1:0] == '0);
        cnt_new   = scan_zero ? r_cnt : (r_cnt + CNT_W'(1));
        consumed  = HELD_W'(cnt_new) + HELD_W'(1);

        n_state     = r_state;
        n_mode      = r_mode;
        n_byte      = r_byte;
        n_len_in    = r_len_in;
        n_last      = r_last;
        n_rp        = r_rp;
        n_wp        = r_wp;
        n_held      = r_held;
        n_cursor    = r_cursor;
        n_open      = r_open;
        n_accepted  = r_accepted;
        n_wrap      = r_wrap;
        n_rec_len   = r_rec_len;
        n_used      = r_used;
        n_scan_base = r_scan_base;
        n_cnt       = r_cnt;
        n_k         = r_k;
        n_out_valid = r_out_valid && !o_out.ready;
        n_kind      = r_kind;
        n_data      = r_data;
        n_eor       = r_eor;
        n_status    = r_status;
        n_slen      = r_slen;
        n_fill      = r_fill;

        mem_wr  = '0;
        rd_en   = 1'b0;
        rd_addr = r_rp;
        alu_a   = r_cursor;
        alu_b   = CNT_W'(1);

        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_mode   = i_in.mode;
                    n_byte   = i_in.byte_value;
                    n_len_in = i_in.record_length;
                    n_last   = i_in.last_byte;
                    if (i_in.mode == vrrb_pkg::MODE_READ) begin
                        n_state = ST_R_CHECK;
                    end else if (!r_open) begin
                        n_state = ST_W_PLACE;
                    end else begin
                        n_state = ST_W_BYTE;
                    end
                end
            end
            ST_W_PLACE: begin
                n_open     = 1'b1;
                n_rec_len  = len_clamp;
                n_accepted = place.accept;
                n_wrap     = place.wrap;
                n_cursor   = place.wrap ? '0 : r_wp;
                n_used     = '0;
                n_state    = ST_W_BYTE;
            end
            ST_W_BYTE: begin
                if (r_accepted && (r_byte != '0) && (r_used < r_rec_len)) begin
                    mem_wr.en   = 1'b1;
                    mem_wr.addr = r_cursor;
                    mem_wr.data = {1'b0, r_byte};
                    n_cursor    = alu_sum;
                    n_used      = r_used + LEN_W'(1);
                end
                if (!r_last) begin
                    n_state = ST_IDLE;
                end else if (!r_accepted) begin
                    n_state = ST_W_ACK;
                end else begin
                    n_state = ST_W_TERM;
                end
            end
            ST_W_TERM: begin
                mem_wr.en   = 1'b1;
                mem_wr.addr = r_cursor;
                mem_wr.data = vrrb_pkg::WORD_TERM;
                n_state     = r_wrap ? ST_W_MARK : ST_W_COMMIT;
            end
            ST_W_MARK: begin
                mem_wr.en   = 1'b1;
                mem_wr.addr = r_wp;
                mem_wr.data = vrrb_pkg::WORD_WRAP;
                n_state     = ST_W_COMMIT;
            end
            ST_W_COMMIT: begin
                if (out_free) begin
                    n_wp        = alu_sum;
                    n_cursor    = alu_sum;
                    n_held      = r_held + HELD_W'(r_used) + HELD_W'(1);
                    n_accepted  = 1'b0;
                    n_open      = 1'b0;
                    n_out_valid = 1'b1;
                    n_kind      = vrrb_pkg::KIND_WRITE_ACK;
                    n_data      = '0;
                    n_eor       = 1'b1;
                    n_status    = vrrb_pkg::STATUS_STORED;
                    n_slen      = CNT_W'(r_used) + CNT_W'(1);
                    n_fill      = FILL_W'(n_held);
                    n_state     = ST_IDLE;
                end
            end
            ST_W_ACK: begin
                if (out_free) begin
                    n_open      = 1'b0;
                    n_out_valid = 1'b1;
                    n_kind      = vrrb_pkg::KIND_WRITE_ACK;
                    n_data      = '0;
                    n_eor       = 1'b1;
                    n_status    = vrrb_pkg::STATUS_DROPPED;
                    n_slen      = '0;
                    n_fill      = FILL_W'(r_held);
                    n_state     = ST_IDLE;
                end
            end
            ST_R_CHECK: begin
                if ((r_rp == r_wp) && (r_held == '0)) begin
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_kind      = vrrb_pkg::KIND_EMPTY;
                        n_data      = '0;
                        n_eor       = 1'b1;
                        n_status    = vrrb_pkg::STATUS_STORED;
                        n_slen      = '0;
                        n_fill      = FILL_W'(r_held);
                        n_state     = ST_IDLE;
                    end
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_rp;
                    n_state = ST_R_MARK;
                end
            end
            ST_R_MARK: begin
                n_scan_base = rd_data[BYTE_W] ? '0 : r_rp;
                n_cnt       = '0;
                n_state     = ST_R_SADDR;
            end
            ST_R_SADDR: begin
                alu_a   = r_scan_base;
                alu_b   = r_cnt;
                rd_en   = 1'b1;
                rd_addr = alu_sum;
                n_state = ST_R_SDATA;
            end
            ST_R_SDATA: begin
                alu_a = r_scan_base;
                alu_b = CNT_W'(consumed);
                n_cnt = cnt_new;
                if (scan_zero || (cnt_new == CNT_W'(vrrb_pkg::MAX_RECORD))) begin
                    n_rp    = alu_sum;
                    n_held  = (r_held >= consumed) ? (r_held - consumed) : '0;
                    n_k     = '0;
                    n_state = (cnt_new == '0) ? ST_R_EMPTYREC : ST_R_EADDR;
                end else begin
                    n_state = ST_R_SADDR;
                end
            end
            ST_R_EMPTYREC: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = vrrb_pkg::KIND_READ_DATA;
                    n_data      = '0;
                    n_eor       = 1'b1;
                    n_status    = vrrb_pkg::STATUS_STORED;
                    n_slen      = '0;
                    n_fill      = FILL_W'(r_held);
                    n_state     = ST_IDLE;
                end
            end
            ST_R_EADDR: begin
                alu_a   = r_scan_base;
                alu_b   = r_k;
                rd_en   = 1'b1;
                rd_addr = alu_sum;
                n_state = ST_R_EDATA;
            end
            ST_R_EDATA: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = vrrb_pkg::KIND_READ_DATA;
                    n_data      = rd_data[BYTE_W-1:0];
                    n_eor       = ((r_k + CNT_W'(1)) == r_cnt);
                    n_status    = vrrb_pkg::STATUS_STORED;
                    n_slen      = '0;
                    n_fill      = FILL_W'(r_held);
                    n_k         = r_k + CNT_W'(1);
                    n_state     = ((r_k + CNT_W'(1)) == r_cnt) ? ST_IDLE : ST_R_EADDR;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rp        <= '0;
            r_wp        <= '0;
            r_held      <= '0;
            r_cursor    <= '0;
            r_open      <= 1'b0;
            r_accepted  <= 1'b0;
            r_wrap      <= 1'b0;
            r_rec_len   <= '0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rp        <= n_rp;
            r_wp        <= n_wp;
            r_held      <= n_held;
            r_cursor    <= n_cursor;
            r_open      <= n_open;
            r_accepted  <= n_accepted;
            r_wrap      <= n_wrap;
            r_rec_len   <= n_rec_len;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
            r_mode      <= n_mode;
            r_byte      <= n_byte;
            r_len_in    <= n_len_in;
            r_last      <= n_last;
            r_scan_base <= n_scan_base;
            r_cnt       <= n_cnt;
            r_k         <= n_k;
            r_kind      <= n_kind;
            r_data      <= n_data;
            r_eor       <= n_eor;
            r_status    <= n_status;
            r_slen      <= n_slen;
            r_fill      <= n_fill;
        end
    end

    a_store_write_only_in_write_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_wr.en |-> (r_mode == vrrb_pkg::MODE_WRITE))
        else $error("store written while a read transaction is in progress");

    a_empty_means_pointers_meet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_IDLE) && (r_held == '0)) |-> (r_rp == r_wp))
        else $error("no bytes held but read and write pointers differ");

    a_ack_length_matches_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_kind == vrrb_pkg::KIND_WRITE_ACK)) |->
            ((r_status == vrrb_pkg::STATUS_DROPPED) == (r_slen == '0)))
        else $error("write acknowledge length disagrees with its status");

    a_scan_within_record_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_R_SDATA) |-> (r_cnt < CNT_W'(vrrb_pkg::MAX_RECORD)))
        else $error("record scan ran past the longest record");

endmodule

>>> tb/sv/vrrb_result_checker.sv
`timescale 1ns / 1ps
// Result checker for the record ring buffer: mirrors store, pointers and open record,
// predicts the results of each input transaction and compares them in arrival order.
// Depends on vrrb_pkg and the channel interfaces in vrrb_if.

module vrrb_result_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    vrrb_in_if   i_in_ch,
    vrrb_out_if  i_out_ch,
    output int   o_fail_count,
    output int   o_pending
);
    import vrrb_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] data;
        logic              eor;
        logic              status;
        logic [CNT_W-1:0]  slen;
        logic [FILL_W-1:0] fill;
    } t_ring_result;

    t_word        mirror_store [STORE_BYTES];
    int           head_ptr     = 0;
    int           tail_ptr     = 0;
    int           held_count   = 0;
    int           fill_cursor  = 0;
    int           open_base    = 0;
    int           open_len     = 0;
    bit           open_flag    = 1'b0;
    bit           open_kept    = 1'b0;
    bit           open_wraps   = 1'b0;
    int           mismatches   = 0;
    t_ring_result awaited_results [$];
    t_ring_result observed;

    function automatic void expect_result(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] data,
                                          logic eor, logic status, logic [CNT_W-1:0] slen);
        t_ring_result r;
        r.kind   = kind;
        r.data   = data;
        r.eor    = eor;
        r.status = status;
        r.slen   = slen;
        r.fill   = held_count[FILL_W-1:0];
        awaited_results.push_back(r);
    endfunction

    function automatic bit place_record(input int need, output int base, output bit wraps);
        wraps = 1'b0;
        base  = tail_ptr;
        if (tail_ptr > head_ptr) begin
            if (STORE_BYTES - tail_ptr >= need) return 1'b1;
            if (head_ptr >= need) begin
                wraps = 1'b1;
                base  = 0;
                return 1'b1;
            end
            return 1'b0;
        end
        if (tail_ptr == head_ptr) begin
            if (held_count != 0) return 1'b0;
            if (STORE_BYTES - tail_ptr < need) begin
                wraps = 1'b1;
                base  = 0;
            end
            return 1'b1;
        end
        return (head_ptr - tail_ptr) >= need;
    endfunction

    function automatic void predict_ring_transaction(logic mode, logic [BYTE_W-1:0] value,
                                                     logic [LEN_W-1:0] len_field,
                                                     logic is_last);
        int                n;
        int                used;
        int                cnt;
        int                k;
        logic [BYTE_W-1:0] taken [MAX_RECORD];
        if (mode == MODE_WRITE) begin
            if (!open_flag) begin
                n = (len_field == 0) ? 1 : int'(len_field);
                if (n > MAX_RECORD) n = MAX_RECORD;
                open_flag   = 1'b1;
                open_len    = n;
                open_kept   = place_record(n + 1, open_base, open_wraps);
                fill_cursor = open_base;
            end
            if (open_kept && value != 0) begin
                used = (fill_cursor + STORE_BYTES - open_base) % STORE_BYTES;
                if (used < open_len) begin
                    mirror_store[fill_cursor] = {1'b0, value};
                    fill_cursor = (fill_cursor + 1) % STORE_BYTES;
                end
            end
            if (is_last) begin
                open_flag = 1'b0;
                if (!open_kept) begin
                    expect_result(KIND_WRITE_ACK, '0, 1'b1, STATUS_DROPPED, '0);
                end else begin
                    used = (fill_cursor + STORE_BYTES - open_base) % STORE_BYTES;
                    mirror_store[fill_cursor] = WORD_TERM;
                    if (open_wraps) mirror_store[tail_ptr] = WORD_WRAP;
                    tail_ptr    = (fill_cursor + 1) % STORE_BYTES;
                    fill_cursor = tail_ptr;
                    held_count += used + 1;
                    open_kept   = 1'b0;
                    expect_result(KIND_WRITE_ACK, '0, 1'b1, STATUS_STORED, CNT_W'(used + 1));
                end
            end
        end else if (head_ptr == tail_ptr && held_count == 0) begin
            expect_result(KIND_EMPTY, '0, 1'b1, STATUS_STORED, '0);
        end else begin
            if (mirror_store[head_ptr][BYTE_W] === 1'b1) head_ptr = 0;
            cnt = 0;
            while (cnt < MAX_RECORD &&
                   mirror_store[(head_ptr + cnt) % STORE_BYTES][BYTE_W-1:0] != '0) begin
                taken[cnt] = mirror_store[(head_ptr + cnt) % STORE_BYTES][BYTE_W-1:0];
                cnt++;
            end
            head_ptr   = (head_ptr + cnt + 1) % STORE_BYTES;
            held_count = (held_count >= cnt + 1) ? held_count - cnt - 1 : 0;
            if (cnt == 0) expect_result(KIND_READ_DATA, '0, 1'b1, STATUS_STORED, '0);
            for (k = 0; k < cnt; k++)
                expect_result(KIND_READ_DATA, taken[k], k == cnt - 1, STATUS_STORED, '0);
        end
    endfunction

    function automatic void check_result(t_ring_result got);
        t_ring_result want;
        if (awaited_results.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
                $write("unexpected result: kind=%0d data=%02h eor=%0d ",
                       got.kind, got.data, got.eor);
                $display("status=%0d len=%0d fill=%0d", got.status, got.slen, got.fill);
            end
            return;
        end
        want = awaited_results.pop_front();
        if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
                $write("result mismatch: expected kind=%0d data=%02h eor=%0d status=%0d ",
                       want.kind, want.data, want.eor, want.status);
                $write("len=%0d fill=%0d, ", want.slen, want.fill);
                $display("got kind=%0d data=%02h eor=%0d status=%0d len=%0d fill=%0d",
                         got.kind, got.data, got.eor, got.status, got.slen, got.fill);
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_out_ch.valid && i_out_ch.ready) begin
                observed.kind   = i_out_ch.kind;
                observed.data   = i_out_ch.data_byte;
                observed.eor    = i_out_ch.end_of_record;
                observed.status = i_out_ch.write_status;
                observed.slen   = i_out_ch.stored_length;
                observed.fill   = i_out_ch.fill_count;
                check_result(observed);
            end
            if (i_in_ch.valid && i_in_ch.ready)
                predict_ring_transaction(i_in_ch.mode, i_in_ch.byte_value,
                                         i_in_ch.record_length, i_in_ch.last_byte);
        end
        o_fail_count <= mismatches;
        o_pending    <= awaited_results.size();
    end

endmodule

>>> tb/sv/variable_record_ring_buffer_tb.sv
`timescale 1ns / 1ps
// Testbench top for the record ring buffer: clock, reset, input transactions and result
// backpressure, with vrrb_result_checker beside the block. Depends on vrrb_pkg, vrrb_if and the block.

module variable_record_ring_buffer_tb;
    import vrrb_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 300;

    logic i_clk;
    logic i_rst_n;

    vrrb_in_if  in_ch ();
    vrrb_out_if out_ch ();

    int fail_count;
    int pending_count;
    int cycle_count = 0;
    int gap_pct     = 10;
    int stall_pct   = 15;
    int stall_left  = 0;
    bit quiet       = 1'b0;

    variable_record_ring_buffer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    vrrb_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_ch      (in_ch),
        .i_out_ch     (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("variable_record_ring_buffer_tb NOT OK");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if ($urandom_range(255) == 0) begin
            case ($urandom_range(2))
                0: stall_pct = 0;
                1: stall_pct = 15;
                default: stall_pct = 40;
            endcase
        end
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            out_ch.ready <= 1'b0;
        end else if (!quiet && $urandom_range(99) < stall_pct) begin
            stall_left = $urandom_range(7, 0);
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    task automatic send_item(logic mode, logic [BYTE_W-1:0] value, logic [LEN_W-1:0] len_field,
                             logic is_last);
        int gap;
        if (!quiet && $urandom_range(99) < gap_pct) begin
            gap = $urandom_range(8, 1);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.mode          <= mode;
        in_ch.byte_value    <= value;
        in_ch.record_length <= len_field;
        in_ch.last_byte     <= is_last;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
    endtask

    task automatic read_oldest();
        send_item(MODE_READ, BYTE_W'($urandom_range(255)), LEN_W'($urandom_range(63)),
                  1'($urandom_range(1)));
    endtask

    task automatic write_record(int len_field, bit noisy);
        int                n;
        int                count;
        int                k;
        logic [BYTE_W-1:0] value;
        logic [LEN_W-1:0]  lf;
        n     = (len_field == 0) ? 1 : len_field;
        count = n;
        if (noisy) begin
            case ($urandom_range(9))
                0: count = $urandom_range(n, 1);
                1: count = n + $urandom_range(3, 1);
                default: ;
            endcase
        end
        for (k = 0; k < count; k++) begin
            value = (noisy && $urandom_range(29) == 0) ? '0 : BYTE_W'($urandom_range(255, 1));
            lf    = (k > 0 && noisy && $urandom_range(6) == 0) ? LEN_W'($urandom_range(63))
                                                              : LEN_W'(len_field);
            send_item(MODE_WRITE, value, lf, k == count - 1);
            if (noisy && k != count - 1 && $urandom_range(39) == 0) read_oldest();
        end
    endtask

    task automatic run_phase(int ops, int write_pct, int min_len, int max_len);
        repeat (ops) begin
            case ($urandom_range(2))
                0: gap_pct = 0;
                1: gap_pct = 10;
                default: gap_pct = 35;
            endcase
            if ($urandom_range(99) < write_pct)
                write_record(($urandom_range(6) == 0) ? $urandom_range(63)
                                                      : $urandom_range(max_len, min_len), 1'b1);
            else
                read_oldest();
        end
    endtask

    initial begin
        in_ch.valid         <= 1'b0;
        in_ch.mode          <= MODE_WRITE;
        in_ch.byte_value    <= '0;
        in_ch.record_length <= '0;
        in_ch.last_byte     <= 1'b0;
        i_rst_n             <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        read_oldest();
        send_item(MODE_WRITE, 8'h01, 6'd0, 1'b1);
        send_item(MODE_WRITE, 8'hFF, 6'd3, 1'b0);
        send_item(MODE_WRITE, 8'h00, 6'd3, 1'b0);
        send_item(MODE_WRITE, 8'h80, 6'd3, 1'b0);
        send_item(MODE_WRITE, 8'h7F, 6'd3, 1'b1);
        send_item(MODE_WRITE, 8'hAA, 6'd2, 1'b0);
        send_item(MODE_WRITE, 8'h55, 6'd2, 1'b0);
        send_item(MODE_WRITE, 8'h33, 6'd2, 1'b1);
        send_item(MODE_WRITE, 8'h11, 6'd63, 1'b1);
        send_item(MODE_WRITE, 8'h00, 6'd5, 1'b1);
        send_item(MODE_WRITE, 8'h42, 6'd4, 1'b0);
        read_oldest();
        send_item(MODE_WRITE, 8'h43, 6'd4, 1'b1);
        repeat (6) read_oldest();

        // mostly writes, then mostly reads, then short records with no idling
        run_phase(8, 70, 1, 12);
        run_phase(10, 30, 1, 12);
        quiet = 1'b1;
        run_phase(8, 50, 0, 8);

        in_ch.valid <= 1'b0;
        while (pending_count != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("variable_record_ring_buffer_tb OK");
        else
            $display("variable_record_ring_buffer_tb NOT OK");
        $finish;
    end

endmodule

>>> variable_record_ring_buffer.f
src/vrrb_pkg.sv
src/vrrb_if.sv
src/vrrb_store.sv
src/vrrb_addr_alu.sv
src/vrrb_place.sv
src/variable_record_ring_buffer.sv
tb/sv/vrrb_result_checker.sv
tb/sv/variable_record_ring_buffer_tb.sv
